@@ src/shs_pkg.sv @@
// shs_pkg: shared constants, tables, types and round functions for the SHA-256 stream hasher.
// No dependencies; compiled first.
package shs_pkg;

   localparam int BLOCK_WORDS  = 16;
   localparam int ROUNDS       = 64;
   localparam int DIGEST_WORDS = 8;
   localparam int ROUND_W      = $clog2(ROUNDS);
   localparam int LOAD_W       = $clog2(BLOCK_WORDS);
   localparam int DIGEST_W     = $clog2(DIGEST_WORDS);

   // word queue between front and core; depth must be a power of two
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0]          PAD_BYTE    = 8'h80;
   localparam logic [LOAD_W-1:0]   LEN_HI_WORD = LOAD_W'(14);

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // one schedule word on its way from front to core
   typedef struct packed {
      logic        last_blk;   // final word of the final block of a message
      logic [31:0] word;
   } word_entry_type;

   typedef enum logic [2:0] {
      F_DATA,
      F_PAD_FIRST,
      F_PAD_ZERO,
      F_LEN_HI,
      F_LEN_LO
   } front_state_type;

   typedef enum logic [1:0] {
      C_LOAD,
      C_ROUND,
      C_UPDATE,
      C_OUT
   } core_state_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

@@ src/shs_if.sv @@
// shs_req_if / shs_rsp_if: valid/ready channel interfaces of the SHA-256 stream hasher.
// No dependencies.
interface shs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output message_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink   (input valid, input message_byte, input byte_present,
                   input end_of_message, output ready);
endinterface

interface shs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

@@ src/sha256_stream_hasher.sv @@
// sha256_stream_hasher: top level of the SHA-256 byte stream hasher.
// Depends on shs_pkg, shs_if, shs_front, shs_fifo and shs_core.
//
// Use:
//  - req_chan (valid/ready) carries one transaction per cycle at most: an optional
//    message byte (byte_present) and an optional end_of_message mark. A transaction
//    with neither is taken and ignored. An empty message is a lone end mark.
//  - rsp_chan (valid/ready) returns the eight digest words of each message,
//    word_index 0 (most significant) first, last_word set on word 7.
// Structure: the front packs bytes into big-endian words and appends the 0x80,
//  zero and 64-bit bit-length padding; a 16-entry word queue sits between it and
//  the compression core, which loads 16 words and then runs one round per cycle.
// Throughput: one byte per cycle while the queue has room. The core handles each
//  64-byte block as 16 word loads, 64 rounds and a state add; it takes words from
//  the queue only while loading.
// Padding: after the end transaction the front pushes one padding word per cycle
//  while the queue has room (up to 18 words when an extra block is needed); the
//  core then compresses each outstanding block before the first digest word appears.
// While padding, req_chan.ready stays low. If the receiver stalls rsp_chan the
//  digest word holds; the front keeps taking bytes of the next message until
//  the queue is full.
// Reset (synchronous, active high) restores the initial hash values, clears the
//  byte count and empties the queue.
module sha256_stream_hasher (
   input  logic      clock,
   input  logic      reset,
   shs_req_if.sink   req_chan,
   shs_rsp_if.source rsp_chan
);

   logic                    push_valid;
   logic                    push_ready;
   shs_pkg::word_entry_type push_entry;
   logic                    pop_valid;
   logic                    pop_ready;
   shs_pkg::word_entry_type pop_entry;

   // byte packing and padding
   shs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // word queue lets the front keep going while the core compresses
   shs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   // compression rounds and digest output
   shs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ src/shs_front.sv @@
// shs_front: takes byte transactions, packs big-endian words and generates the padding.
// Depends on shs_pkg and shs_req_if.
module shs_front (
   input  logic                    clock,
   input  logic                    reset,
   shs_req_if.sink                 req_chan,
   output logic                    push_valid,
   input  logic                    push_ready,
   output shs_pkg::word_entry_type push_entry
);

   shs_pkg::front_state_type state_ff, state_in;
   logic [63:0] count_ff, count_in;
   logic [23:0] acc_ff, acc_in;
   logic [3:0]  pad_pos_ff, pad_pos_in;
   logic        take;
   logic [3:0]  first_next;
   logic [31:0] pad_word;
   logic [31:0] acc_word;

   assign req_chan.ready = (state_ff == shs_pkg::F_DATA) && push_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign first_next     = count_ff[5:2] + 4'd1;
   assign acc_word       = {acc_ff, 8'h00};

   // bytes already held, then 0x80, then zeros
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         if (2'(j) < count_ff[1:0]) begin
            pad_word[31-8*j -: 8] = acc_word[31-8*j -: 8];
         end else if (2'(j) == count_ff[1:0]) begin
            pad_word[31-8*j -: 8] = shs_pkg::PAD_BYTE;
         end else begin
            pad_word[31-8*j -: 8] = 8'h00;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         shs_pkg::F_DATA: begin
            if (take && req_chan.end_of_message) begin
               state_in = shs_pkg::F_PAD_FIRST;
            end
         end
         shs_pkg::F_PAD_FIRST: begin
            if (push_ready) begin
               state_in = (first_next == shs_pkg::LEN_HI_WORD) ? shs_pkg::F_LEN_HI
                                                              : shs_pkg::F_PAD_ZERO;
            end
         end
         shs_pkg::F_PAD_ZERO: begin
            if (push_ready && (pad_pos_ff + 4'd1 == shs_pkg::LEN_HI_WORD)) begin
               state_in = shs_pkg::F_LEN_HI;
            end
         end
         shs_pkg::F_LEN_HI: begin
            if (push_ready) begin
               state_in = shs_pkg::F_LEN_LO;
            end
         end
         shs_pkg::F_LEN_LO: begin
            if (push_ready) begin
               state_in = shs_pkg::F_DATA;
            end
         end
         default: state_in = shs_pkg::F_DATA;
      endcase
   end

   // outputs towards the queue
   always_comb begin
      push_valid          = 1'b0;
      push_entry.last_blk = 1'b0;
      push_entry.word     = 32'h0;
      case (state_ff)
         shs_pkg::F_DATA: begin
            push_valid      = take && req_chan.byte_present && (count_ff[1:0] == 2'd3);
            push_entry.word = {acc_ff, req_chan.message_byte};
         end
         shs_pkg::F_PAD_FIRST: begin
            push_valid      = 1'b1;
            push_entry.word = pad_word;
         end
         shs_pkg::F_PAD_ZERO: begin
            push_valid = 1'b1;
         end
         shs_pkg::F_LEN_HI: begin
            push_valid      = 1'b1;
            push_entry.word = count_ff[60:29];
         end
         shs_pkg::F_LEN_LO: begin
            push_valid          = 1'b1;
            push_entry.word     = {count_ff[28:0], 3'b000};
            push_entry.last_blk = 1'b1;
         end
         default: push_valid = 1'b0;
      endcase
   end

   // byte count, partial word and pad position
   always_comb begin
      count_in   = count_ff;
      acc_in     = acc_ff;
      pad_pos_in = pad_pos_ff;
      case (state_ff)
         shs_pkg::F_DATA: begin
            if (take && req_chan.byte_present) begin
               count_in = count_ff + 64'd1;
               case (count_ff[1:0])
                  2'd0:    acc_in[23:16] = req_chan.message_byte;
                  2'd1:    acc_in[15:8]  = req_chan.message_byte;
                  2'd2:    acc_in[7:0]   = req_chan.message_byte;
                  default: acc_in        = acc_ff;
               endcase
            end
         end
         shs_pkg::F_PAD_FIRST: begin
            pad_pos_in = first_next;
         end
         shs_pkg::F_PAD_ZERO: begin
            if (push_ready) begin
               pad_pos_in = pad_pos_ff + 4'd1;
            end
         end
         shs_pkg::F_LEN_LO: begin
            if (push_ready) begin
               count_in = 64'd0;
            end
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shs_pkg::F_DATA;
         count_ff <= 64'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      pad_pos_ff <= pad_pos_in;
   end

endmodule

@@ src/shs_fifo.sv @@
// shs_fifo: short word queue that decouples the front from the compression core.
// Depends on shs_pkg.
module shs_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  shs_pkg::word_entry_type push_entry,
   output logic                    push_ready,
   output logic                    pop_valid,
   output shs_pkg::word_entry_type pop_entry,
   input  logic                    pop_ready
);

   shs_pkg::word_entry_type slot_ff [shs_pkg::FIFO_DEPTH];
   logic [shs_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [shs_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [shs_pkg::FIFO_CW-1:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign push_ready = (fill_ff != shs_pkg::FIFO_CW'(shs_pkg::FIFO_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ src/shs_core.sv @@
// shs_core: 16-word schedule window, one compression round per cycle, digest output.
// Depends on shs_pkg and shs_rsp_if.
module shs_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   input  shs_pkg::word_entry_type pop_entry,
   output logic                    pop_ready,
   shs_rsp_if.source               rsp_chan
);

   shs_pkg::core_state_type state_ff, state_in;
   logic [31:0] hash_ff  [shs_pkg::DIGEST_WORDS];
   logic [31:0] hash_in  [shs_pkg::DIGEST_WORDS];
   logic [31:0] work_ff  [shs_pkg::DIGEST_WORDS];
   logic [31:0] work_in  [shs_pkg::DIGEST_WORDS];
   logic [31:0] sched_ff [shs_pkg::BLOCK_WORDS];
   logic [31:0] sched_in [shs_pkg::BLOCK_WORDS];
   logic [shs_pkg::LOAD_W-1:0]   load_cnt_ff, load_cnt_in;
   logic [shs_pkg::ROUND_W-1:0]  round_ff, round_in;
   logic [shs_pkg::DIGEST_W-1:0] out_idx_ff, out_idx_in;
   logic        last_blk_ff, last_blk_in;
   logic        do_pop, do_send, load_done, rounds_done, out_done;
   logic [31:0] t1, t2, ch, maj, sched_new;

   assign do_pop      = pop_valid && pop_ready;
   assign do_send     = rsp_chan.valid && rsp_chan.ready;
   assign load_done   = do_pop && (load_cnt_ff == shs_pkg::LOAD_W'(shs_pkg::BLOCK_WORDS - 1));
   assign rounds_done = (round_ff == shs_pkg::ROUND_W'(shs_pkg::ROUNDS - 1));
   assign out_done    = do_send && (out_idx_ff == shs_pkg::DIGEST_W'(shs_pkg::DIGEST_WORDS - 1));

   // round datapath: work_ff holds a..h, sched_ff[0] is this round's W
   assign ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
              ^ (work_ff[1] & work_ff[2]);
   assign t1  = work_ff[7] + shs_pkg::big_sigma1(work_ff[4]) + ch
              + shs_pkg::ROUND_K[round_ff] + sched_ff[0];
   assign t2  = shs_pkg::big_sigma0(work_ff[0]) + maj;
   assign sched_new = shs_pkg::small_sigma1(sched_ff[14]) + sched_ff[9]
                    + shs_pkg::small_sigma0(sched_ff[1]) + sched_ff[0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         shs_pkg::C_LOAD:   if (load_done)   state_in = shs_pkg::C_ROUND;
         shs_pkg::C_ROUND:  if (rounds_done) state_in = shs_pkg::C_UPDATE;
         shs_pkg::C_UPDATE: state_in = last_blk_ff ? shs_pkg::C_OUT : shs_pkg::C_LOAD;
         shs_pkg::C_OUT:    if (out_done)    state_in = shs_pkg::C_LOAD;
         default:           state_in = shs_pkg::C_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready            = 1'b0;
      rsp_chan.valid       = 1'b0;
      case (state_ff)
         shs_pkg::C_LOAD: pop_ready      = 1'b1;
         shs_pkg::C_OUT:  rsp_chan.valid = 1'b1;
         default:         pop_ready      = 1'b0;
      endcase
   end

   assign rsp_chan.digest_word = hash_ff[out_idx_ff];
   assign rsp_chan.word_index  = out_idx_ff;
   assign rsp_chan.last_word   = (out_idx_ff == shs_pkg::DIGEST_W'(shs_pkg::DIGEST_WORDS - 1));

   // datapath next values
   always_comb begin
      hash_in     = hash_ff;
      work_in     = work_ff;
      sched_in    = sched_ff;
      load_cnt_in = load_cnt_ff;
      round_in    = round_ff;
      out_idx_in  = out_idx_ff;
      last_blk_in = last_blk_ff;
      case (state_ff)
         shs_pkg::C_LOAD: begin
            if (do_pop) begin
               for (int i = 0; i < shs_pkg::BLOCK_WORDS - 1; i++) begin
                  sched_in[i] = sched_ff[i+1];
               end
               sched_in[shs_pkg::BLOCK_WORDS-1] = pop_entry.word;
               load_cnt_in = load_cnt_ff + 1'b1;
               if (load_done) begin
                  work_in     = hash_ff;
                  round_in    = '0;
                  last_blk_in = pop_entry.last_blk;
               end
            end
         end
         shs_pkg::C_ROUND: begin
            for (int i = 0; i < shs_pkg::BLOCK_WORDS - 1; i++) begin
               sched_in[i] = sched_ff[i+1];
            end
            sched_in[shs_pkg::BLOCK_WORDS-1] = sched_new;
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            round_in   = round_ff + 1'b1;
         end
         shs_pkg::C_UPDATE: begin
            for (int i = 0; i < shs_pkg::DIGEST_WORDS; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
            out_idx_in = '0;
         end
         shs_pkg::C_OUT: begin
            if (do_send) begin
               out_idx_in = out_idx_ff + 1'b1;
               if (out_done) begin
                  hash_in = shs_pkg::INIT_HASH;
               end
            end
         end
         default: round_in = round_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= shs_pkg::C_LOAD;
         hash_ff     <= shs_pkg::INIT_HASH;
         load_cnt_ff <= '0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         hash_ff     <= hash_in;
         load_cnt_ff <= load_cnt_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      sched_ff    <= sched_in;
      round_ff    <= round_in;
      last_blk_ff <= last_blk_in;
   end

endmodule

@@ src/shs_checker.sv @@
// shs_checker: port-level assertions for sha256_stream_hasher, with its bind.
// Depends on sha256_stream_hasher and the shs_req_if / shs_rsp_if interfaces.
module shs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_end_of_message,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // digest words come out in order without gaps
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word index did not advance by one");

   a_last_on_seven: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word does not match word index 7");

   // no digest word is offered straight after the last one is taken
   a_gap_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> !rsp_valid)
      else $error("result valid straight after the last digest word");

   // padding occupies the front right after an end transaction
   a_pad_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_message) |=> !req_ready)
      else $error("input taken while padding");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_digest_word)))
      else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_end_of_message (req_chan.end_of_message),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_digest_word    (rsp_chan.digest_word),
   .rsp_word_index     (rsp_chan.word_index),
   .rsp_last_word      (rsp_chan.last_word)
);
